// ===== rtl/lfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame diff flusher package
// Shared widths, operation codes and command byte constants.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int LFD_LED_COUNT = 60;
    localparam int OP_W          = 2;
    localparam int IDX_W         = 7;
    localparam int COLOR_W       = 8;
    localparam int BYTE_W        = 8;
    localparam int LIMIT_W       = 6;

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [COLOR_W-1:0] t_color;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [LIMIT_W-1:0] t_limit;

    localparam t_op OP_SET   = 2'd0;
    localparam t_op OP_FILL  = 2'd1;
    localparam t_op OP_FLUSH = 2'd2;

    localparam t_byte  ADDR_MARK   = 8'h80;
    localparam t_byte  REPAINT     = 8'h40;
    localparam t_limit LIMIT_MAX   = 6'd62;
    localparam t_limit LIMIT_RESET = 6'd32;

endpackage

// ===== rtl/lfd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame diff flusher channels
// Valid/ready channels for command items and output command bytes.
// ----------------------------------------------------------------------------
interface lfd_in_if
    import lfd_pkg::*;
;
    logic   valid;
    logic   ready;
    t_op    op;
    t_idx   led_index;
    t_color color;

    modport source (output valid, output op, output led_index, output color, input ready);
    modport sink   (input valid, input op, input led_index, input color, output ready);
endinterface

interface lfd_out_if
    import lfd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/led_frame_diff_flusher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame diff flusher
// Frame and shadow stores of LED colors; a flush streams changed entries as
// index/color byte pairs, capped by a byte limit, then a repaint byte if any went out.
// ----------------------------------------------------------------------------
// Set and unused ops leave the block idle. Fill writes one store entry per
// cycle. Flush reads each entry scanned from the registered store, then
// compares it; each output byte waits for its transfer, so o_out can stall
// the flush. One item at a time; the input is not ready until it is done.
// Synchronous active-low reset clears per-entry valid bits, so both stores
// read as zero right away; limit register resets to 32.
// ----------------------------------------------------------------------------
module led_frame_diff_flusher_top
    import lfd_pkg::*;
#(
    parameter int LED_COUNT = LFD_LED_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  t_limit        i_cfg_wdata,
    lfd_in_if.sink        i_in,
    lfd_out_if.source     o_out
);

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LED_COUNT - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_IDX  = 3'd4;
    localparam logic [2:0] S_COL  = 3'd5;
    localparam logic [2:0] S_REP  = 3'd6;

    t_color r_frame_mem [LED_COUNT];
    t_color r_sent_mem  [LED_COUNT];
    logic [LED_COUNT-1:0] r_fvld, r_svld;

    logic [2:0]    r_state;
    logic [AW-1:0] r_addr;
    t_color        r_fill_color;
    t_limit        r_limit;
    t_limit        r_count;
    t_color        r_frame_q, r_sent_q;
    logic          r_fvld_q, r_svld_q;
    t_color        r_cur;
    logic          r_ovalid;
    t_byte         r_obyte;
    logic          r_olast;

    logic   in_xfer, out_xfer;
    logic   set_hit;
    t_color fval, sval;
    t_limit lim;
    logic   frame_we, sent_we;
    logic [AW-1:0] frame_waddr;
    t_color frame_wdata;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_ovalid && o_out.ready;
    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.out_byte = r_obyte;
    assign o_out.last     = r_olast;

    assign set_hit = ({1'b0, i_in.led_index} < 8'(LED_COUNT));
    assign fval    = r_fvld_q ? r_frame_q : '0;
    assign sval    = r_svld_q ? r_sent_q : '0;
    assign lim     = (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;

    always_comb begin
        frame_we    = 1'b0;
        frame_waddr = r_addr;
        frame_wdata = r_fill_color;
        if (in_xfer && i_in.op == OP_SET && set_hit) begin
            frame_we    = 1'b1;
            frame_waddr = i_in.led_index[AW-1:0];
            frame_wdata = i_in.color;
        end else if (r_state == S_FILL) begin
            frame_we = 1'b1;
        end
        sent_we = (r_state == S_IDX) && out_xfer;
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frame_mem[frame_waddr] <= frame_wdata;
        end
        if (sent_we) begin
            r_sent_mem[r_addr] <= r_cur;
        end
        r_frame_q <= r_frame_mem[r_addr];
        r_sent_q  <= r_sent_mem[r_addr];
        r_fvld_q  <= r_fvld[r_addr];
        r_svld_q  <= r_svld[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
            r_svld <= '0;
        end else begin
            if (frame_we) begin
                r_fvld[frame_waddr] <= 1'b1;
            end
            if (sent_we) begin
                r_svld[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_olast  <= 1'b0;
            r_addr   <= '0;
            r_count  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_addr       <= '0;
                        r_count      <= '0;
                        r_fill_color <= i_in.color;
                        if (i_in.op == OP_FILL) begin
                            r_state <= S_FILL;
                        end else if (i_in.op == OP_FLUSH) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_FILL: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (fval != sval) begin
                        r_cur    <= fval;
                        r_ovalid <= 1'b1;
                        r_olast  <= 1'b0;
                        r_obyte  <= ADDR_MARK | {1'b0, 7'(r_addr)};
                        r_state  <= S_IDX;
                    end else if (r_addr == LAST_ADDR) begin
                        if (r_count != '0) begin
                            r_ovalid <= 1'b1;
                            r_olast  <= 1'b1;
                            r_obyte  <= REPAINT;
                            r_state  <= S_REP;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_addr  <= r_addr + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_IDX: begin
                    if (out_xfer) begin
                        r_obyte <= r_cur;
                        r_count <= r_count + 6'd2;
                        r_state <= S_COL;
                    end
                end
                S_COL: begin
                    if (out_xfer) begin
                        if (r_count >= lim || r_addr == LAST_ADDR) begin
                            r_obyte <= REPAINT;
                            r_olast <= 1'b1;
                            r_state <= S_REP;
                        end else begin
                            r_ovalid <= 1'b0;
                            r_addr   <= r_addr + 1'b1;
                            r_state  <= S_READ;
                        end
                    end
                end
                S_REP: begin
                    if (out_xfer) begin
                        r_ovalid <= 1'b0;
                        r_olast  <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_ovalid <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED frame diff flusher testbench
// Drives set, fill and flush commands over the input channel with random
// idle bursts on both channels, and predicts every command byte that a flush
// streams out. A short table of directed commands goes first, run at the
// reset byte limit. Random phases follow, each at its own byte limit,
// including zero and values above the cap. Every output transfer is compared
// with the oldest predicted byte.
// ----------------------------------------------------------------------------
module testbench;
    import lfd_pkg::*;

    localparam int  CLK_HALF        = 6;
    localparam int  RESET_CYCLES    = 9;
    localparam int  LATENCY_CYCLES  = 2 * LFD_LED_COUNT + 16;
    localparam int  DRAIN_LIMIT     = 50000;
    localparam int  PHASES          = 6;
    localparam int  ITEMS_PER_PHASE = 23;
    localparam int  TIMEOUT_NS      = 7_200_000;
    localparam t_op OP_UNUSED       = 2'd3;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PAIR
    } t_chk;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_tx;

    typedef struct packed {
        t_op    op;
        t_idx   idx;
        t_color color;
        t_chk   chk;
        t_byte  addr_b;
        t_byte  color_b;
    } t_row;

    localparam int N_DIRECTED = 23;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{OP_FLUSH,  7'd0,   8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_SET,    7'd0,   8'hFF, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_PAIR,  8'h80, 8'hFF},
        '{OP_SET,    7'd127, 8'h55, CHK_NONE,  8'h00, 8'h00},
        '{OP_SET,    7'd60,  8'h55, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_SET,    7'd59,  8'h01, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd127, 8'hFF, CHK_PAIR,  8'hBB, 8'h01},
        '{OP_UNUSED, 7'd5,   8'h77, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_SET,    7'd5,   8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_FILL,   7'd0,   8'hAA, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_MODEL, 8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_MODEL, 8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_MODEL, 8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_MODEL, 8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_FILL,   7'd127, 8'h00, CHK_NONE,  8'h00, 8'h00},
        '{OP_SET,    7'd30,  8'h80, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_MODEL, 8'h00, 8'h00},
        '{OP_FILL,   7'd0,   8'hFF, CHK_NONE,  8'h00, 8'h00},
        '{OP_FLUSH,  7'd0,   8'h00, CHK_MODEL, 8'h00, 8'h00}
    };

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    t_limit cfg_wdata;

    lfd_in_if  in_ch ();
    lfd_out_if out_ch ();

    led_frame_diff_flusher_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_color frame_img [LFD_LED_COUNT];
    t_color sent_img  [LFD_LED_COUNT];
    t_limit byte_cap;
    t_tx    flush_burst [$];
    t_tx    expected_tx [$];
    int     n_errors;
    bit     quiet;

    always #CLK_HALF clk = ~clk;

    function automatic void model_command(t_op op, t_idx idx, t_color color);
        int limit;
        int count;
        flush_burst.delete();
        case (op)
            OP_SET: begin
                if (idx < LFD_LED_COUNT) frame_img[idx] = color;
            end
            OP_FILL: begin
                foreach (frame_img[x]) frame_img[x] = color;
            end
            OP_FLUSH: begin
                limit = (byte_cap > LIMIT_MAX) ? LIMIT_MAX : byte_cap;
                count = 0;
                for (int x = 0; x < LFD_LED_COUNT; x++) begin
                    if (frame_img[x] != sent_img[x]) begin
                        flush_burst.push_back('{ADDR_MARK | t_byte'(x), 1'b0});
                        flush_burst.push_back('{frame_img[x], 1'b0});
                        count += 2;
                        sent_img[x] = frame_img[x];
                        if (count >= limit) break;
                    end
                end
                if (count != 0) flush_burst.push_back('{REPAINT, 1'b1});
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_cmd(input t_op op, input t_idx idx, input t_color color,
                            input t_chk chk, input t_byte addr_b, input t_byte color_b);
        int gap;
        if (!quiet && $urandom_range(0, 1) == 0) begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.op        <= op;
        in_ch.led_index <= idx;
        in_ch.color     <= color;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        model_command(op, idx, color);
        case (chk)
            CHK_MODEL: begin
                foreach (flush_burst[k]) expected_tx.push_back(flush_burst[k]);
            end
            CHK_PAIR: begin
                expected_tx.push_back('{addr_b, 1'b0});
                expected_tx.push_back('{color_b, 1'b0});
                expected_tx.push_back('{REPAINT, 1'b1});
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_random();
        int     pick;
        t_op    op;
        t_idx   idx;
        t_color color;
        pick  = $urandom_range(0, 99);
        idx   = t_idx'($urandom_range(0, LFD_LED_COUNT - 1));
        color = t_color'($urandom);
        if (pick < 40) begin
            op = OP_SET;
        end else if (pick < 45) begin
            op  = OP_SET;
            idx = t_idx'($urandom_range(LFD_LED_COUNT, 127));
        end else if (pick < 55) begin
            op = OP_FILL;
        end else if (pick < 95) begin
            op = OP_FLUSH;
        end else begin
            op  = OP_UNUSED;
            idx = t_idx'($urandom);
        end
        send_cmd(op, idx, color, CHK_MODEL, 8'h00, 8'h00);
    endtask

    task automatic write_byte_cap(input t_limit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        byte_cap = value;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (expected_tx.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY_CYCLES) @(posedge clk);
        if (expected_tx.size() != 0) begin
            $error("%0d command bytes never arrived", expected_tx.size());
            n_errors++;
            expected_tx.delete();
        end
    endtask

    // Check each output transfer against the oldest predicted byte.
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_tx.size() == 0) begin
                $error("out_byte: expected none, actual %02h", out_ch.out_byte);
                n_errors++;
            end else begin
                if (out_ch.out_byte !== expected_tx[0].data) begin
                    $error("out_byte: expected %02h, actual %02h",
                           expected_tx[0].data, out_ch.out_byte);
                    n_errors++;
                end
                if (out_ch.last !== expected_tx[0].last) begin
                    $error("last: expected %0b, actual %0b",
                           expected_tx[0].last, out_ch.last);
                    n_errors++;
                end
                void'(expected_tx.pop_front());
            end
        end
    end

    // Stall the output channel in random bursts until the quiet phase.
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 11);
                repeat (n) begin
                    out_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            n = $urandom_range(1, 30);
            repeat (n) begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_SET;
        in_ch.led_index = '0;
        in_ch.color     = '0;
        n_errors        = 0;
        quiet           = 1'b0;
        byte_cap        = LIMIT_RESET;
        foreach (frame_img[x]) begin
            frame_img[x] = '0;
            sent_img[x]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k]) begin
            send_cmd(DIRECTED[k].op, DIRECTED[k].idx, DIRECTED[k].color,
                     DIRECTED[k].chk, DIRECTED[k].addr_b, DIRECTED[k].color_b);
        end
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       write_byte_cap(6'd0);
                1:       write_byte_cap(6'd63);
                2:       write_byte_cap(6'd1);
                3:       write_byte_cap(LIMIT_MAX);
                default: write_byte_cap(t_limit'($urandom_range(2, 61)));
            endcase
            quiet = (p == PHASES - 1);
            repeat (ITEMS_PER_PHASE) send_random();
            settle();
        end

        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
